### sv/dmm_pkg.sv
// dmm_pkg: shared types and constants for the disjunction min-match merge.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dmm_pkg;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 21;
    localparam int unsigned SUM_BITS = 19;
    localparam int unsigned CNT_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_MATCHERS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_DOC = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_DOC = 2'd2;
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_FETCH = 1'b1;
endpackage
`default_nettype wire

### sv/dmm_ram.sv
// dmm_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dmm_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### sv/disjunction_min_match_merge.sv
// disjunction_min_match_merge: k-way posting list union with min-should-match.
// Depends on dmm_pkg and dmm_ram.
//
//  channel | signals                                  | direction
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data        | in, write only
//  in      | i_in_valid/o_in_ready + request fields   | in
//  out     | o_out_valid/i_out_ready + hit fields     | out
//
// An append reads the last doc of the list (S_APP_RD), then compares and writes.
// A fetch reads every list head through the one RAM address, one list at a time:
// a find pass (S_SC_RD, S_SC_CHK per list), one decide state and, if the
// candidate qualifies, a consume pass (S_CON_RD, S_CON_CHK per list), then S_OUT.
// Skipped documents add candidates. One word in flight: not ready until an
// append ends or a fetch result is taken. Reset (sync, active low) clears
// fill counts and read pointers; the stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module disjunction_min_match_merge #(
    parameter int unsigned NUM_LISTS = 8,
    parameter int unsigned LIST_DEPTH = 256,
    parameter int unsigned DOC_BITS = 20,
    parameter int unsigned SCORE_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dmm_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [dmm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_req_type,
    input  wire logic [2:0]                         i_list_index,
    input  wire logic [DOC_BITS-1:0]                i_doc_id,
    input  wire logic [SCORE_BITS-1:0]              i_posting_score,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_hit_valid,
    output logic [19:0]                             o_hit_doc,
    output logic [dmm_pkg::SUM_BITS-1:0]            o_score_sum,
    output logic [dmm_pkg::CNT_BITS-1:0]            o_matcher_count
);
    localparam int unsigned LB = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int unsigned PB = $clog2(LIST_DEPTH);
    localparam int unsigned FB = PB + 1;
    localparam int unsigned AB = $clog2(NUM_LISTS * LIST_DEPTH);
    localparam int unsigned CB = $clog2(NUM_LISTS + 1);
    localparam int unsigned SB = SCORE_BITS + CB;
    localparam logic [SB-1:0] SUM_MAX = SB'(524287);

    typedef enum logic [3:0] {
        S_IDLE, S_APP_RD, S_APP_CMP, S_SC_RD, S_SC_CHK, S_DECIDE,
        S_CON_RD, S_CON_CHK, S_OUT
    } t_state;

    t_state               r_state;
    logic [3:0]           r_min;
    logic [19:0]          r_start;
    logic [20:0]          r_end;
    logic [FB-1:0]        r_fill [NUM_LISTS];
    logic [FB-1:0]        r_rptr [NUM_LISTS];
    logic [LB-1:0]        r_li;
    logic [DOC_BITS-1:0]  r_doc;
    logic [SCORE_BITS-1:0] r_score;
    logic [LB:0]          r_scan;
    logic [DOC_BITS-1:0]  r_best;
    logic                 r_found;
    logic [CB-1:0]        r_active;
    logic [CB-1:0]        r_cnt;
    logic [SB-1:0]        r_sum;
    logic                 r_out_valid;
    logic                 r_hit;
    logic [19:0]          r_hit_doc;
    logic [dmm_pkg::SUM_BITS-1:0] r_hit_sum;
    logic [dmm_pkg::CNT_BITS-1:0] r_hit_cnt;

    logic                 ram_we;
    logic [AB-1:0]        ram_addr;
    logic [DOC_BITS-1:0]  rd_doc;
    logic [SCORE_BITS-1:0] rd_score;
    logic [LB-1:0]        scan_l;
    logic                 scan_act;
    logic [CB:0]          need;
    logic [SB-1:0]        sum_add;

    assign scan_l = r_scan[LB-1:0];
    assign scan_act = (r_rptr[scan_l] < r_fill[scan_l]);
    assign need = (r_min == 4'd0) ? (CB+1)'(1) : (CB+1)'(r_min);
    assign sum_add = r_sum + SB'(rd_score);

    always_comb begin
        ram_we = 1'b0;
        ram_addr = '0;
        unique case (r_state)
            S_APP_RD: ram_addr = AB'({r_li, PB'(r_fill[r_li] - FB'(1))});
            S_APP_CMP: begin
                ram_addr = AB'({r_li, r_fill[r_li][PB-1:0]});
                ram_we = (r_fill[r_li] < FB'(LIST_DEPTH))
                         && ((r_fill[r_li] == '0) || (r_doc > rd_doc));
            end
            S_SC_RD, S_CON_RD: ram_addr = AB'({scan_l, r_rptr[scan_l][PB-1:0]});
            default: ram_addr = '0;
        endcase
    end

    dmm_ram #(.WIDTH(DOC_BITS), .DEPTH(NUM_LISTS * LIST_DEPTH)) u_doc_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(r_doc), .o_rdata(rd_doc));
    dmm_ram #(.WIDTH(SCORE_BITS), .DEPTH(NUM_LISTS * LIST_DEPTH)) u_score_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(r_score), .o_rdata(rd_score));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min <= 4'd1;
            r_start <= '0;
            r_end <= 21'h100000;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_fill[i] <= '0;
                r_rptr[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dmm_pkg::REG_MIN_MATCHERS: r_min <= i_cfg_data[3:0];
                    dmm_pkg::REG_START_DOC:    r_start <= i_cfg_data[19:0];
                    dmm_pkg::REG_END_DOC:      r_end <= i_cfg_data[20:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_doc <= i_doc_id;
                        r_score <= i_posting_score;
                        r_li <= LB'(i_list_index);
                        r_scan <= '0;
                        r_found <= 1'b0;
                        r_active <= '0;
                        if (i_req_type == dmm_pkg::REQ_FETCH) begin
                            r_state <= S_SC_RD;
                        end else if (32'(i_list_index) < NUM_LISTS) begin
                            r_state <= S_APP_RD;
                        end
                    end
                end
                S_APP_RD: r_state <= S_APP_CMP;
                S_APP_CMP: begin
                    if (ram_we) r_fill[r_li] <= r_fill[r_li] + FB'(1);
                    r_state <= S_IDLE;
                end
                S_SC_RD: r_state <= S_SC_CHK;
                S_SC_CHK: begin
                    if (scan_act) begin
                        r_active <= r_active + CB'(1);
                        if (!r_found || rd_doc < r_best) begin
                            r_best <= rd_doc;
                            r_found <= 1'b1;
                        end
                    end
                    if (32'(r_scan) == NUM_LISTS - 1) r_state <= S_DECIDE;
                    else begin
                        r_scan <= r_scan + (LB+1)'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_DECIDE: begin
                    r_scan <= '0;
                    r_cnt <= '0;
                    r_sum <= '0;
                    if (!r_found || (CB+1)'(r_active) < need
                        || 32'(r_best) >= 32'(r_end)) begin
                        r_hit <= 1'b0;
                        r_hit_doc <= '0;
                        r_hit_sum <= '0;
                        r_hit_cnt <= '0;
                        r_out_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CON_RD;
                    end
                end
                S_CON_RD: r_state <= S_CON_CHK;
                S_CON_CHK: begin
                    if (scan_act && rd_doc == r_best) begin
                        r_rptr[scan_l] <= r_rptr[scan_l] + FB'(1);
                        r_cnt <= r_cnt + CB'(1);
                        r_sum <= (sum_add < r_sum || sum_add > SUM_MAX)
                                 ? SUM_MAX : sum_add;
                    end
                    if (32'(r_scan) == NUM_LISTS - 1) begin
                        r_scan <= '0;
                        r_found <= 1'b0;
                        r_active <= '0;
                        r_state <= S_SC_RD;
                        // final count/sum include this lane
                        if (32'(r_best) >= 32'(r_start)) begin
                            if ((CB+1)'(r_cnt) + (CB+1)'(scan_act && rd_doc == r_best)
                                >= need) begin
                                r_hit <= 1'b1;
                                r_hit_doc <= 20'(r_best);
                                r_hit_sum <= (scan_act && rd_doc == r_best)
                                    ? dmm_pkg::SUM_BITS'((sum_add < r_sum
                                        || sum_add > SUM_MAX) ? SUM_MAX : sum_add)
                                    : dmm_pkg::SUM_BITS'(r_sum);
                                r_hit_cnt <= dmm_pkg::CNT_BITS'(r_cnt
                                    + CB'(scan_act && rd_doc == r_best));
                                r_out_valid <= 1'b1;
                                r_state <= S_OUT;
                            end
                        end
                    end else begin
                        r_scan <= r_scan + (LB+1)'(1);
                        r_state <= S_CON_RD;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit_valid = r_hit;
    assign o_hit_doc = r_hit_doc;
    assign o_score_sum = r_hit_sum;
    assign o_matcher_count = r_hit_cnt;
endmodule
`default_nettype wire
